// ----- rtl/char_class_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the character class tokenizer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_CLASS_TOKENIZER_MACROS_SVH
`define CHAR_CLASS_TOKENIZER_MACROS_SVH

// Same-cycle implication
`define CCT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants of the character class tokenizer.
// ----------------------------------------------------------------------------
package cct_pkg;

	localparam int CFG_AW = 6;

	// Byte classes, in falling priority
	typedef enum logic [2:0] {
		CLS_LINE,
		CLS_WORD,
		CLS_SYM,
		CLS_COPEN,
		CLS_CCLOSE,
		CLS_ESC,
		CLS_OTHER
	} cls_t;

	// Result event codes
	typedef enum logic [2:0] {
		EV_TOKEN_BYTE,
		EV_TOKEN_END,
		EV_SYMBOL,
		EV_LINE_END,
		EV_STREAM_END,
		EV_STRAY_CLOSE,
		EV_ESC_AT_END
	} ev_t;

	typedef struct packed {
		logic [63:0] word_set;
		logic [63:0] line_set;
		logic [63:0] sym_set;
		logic [63:0] copen_set;
		logic [63:0] cclose_set;
		logic [7:0]  esc_byte;
		logic [63:0] extra_set;
	} cfg_t;

	// Classified input item
	typedef struct packed {
		logic       eos;
		logic [7:0] data;
		cls_t       cls;
		logic       xdelim;
	} item_t;

	typedef struct packed {
		ev_t         ev;
		logic [7:0]  data;
		logic [15:0] count;
	} res_t;

	// One item's results: up to two
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} step_out_t;

endpackage

// ----- rtl/char_class_tokenizer.sv -----
// ----------------------------------------------------------------------------
// char_class_tokenizer
// Streaming byte tokenizer with configurable character classes.
// ----------------------------------------------------------------------------
// A byte's first result passes through the input register, then the result register,
// on its way to the outputs.
// Throughput: one item per cycle while out_ready is high and no item gives two results;
// an item with two results takes two transfers and holds the input until the second.
// Reset: arst_n clears mode, line record and counter, and the registers return
// to space/tab word delimiters and LF/CR line delimiters.
// ----------------------------------------------------------------------------
module char_class_tokenizer #(
	parameter int SET_SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cct_pkg::CFG_AW-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic [7:0]                 in_byte,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 event_res,
	output logic [7:0]                 out_byte,
	output logic [15:0]                line_count,
	output logic                       last
);

	cct_pkg::cfg_t      cfg;
	cct_pkg::item_t     item_in;
	cct_pkg::item_t     item_s1;
	logic               v_s1;
	cct_pkg::step_out_t sout;
	logic               free;
	logic               adv;

	// Register file; the user must change configuration only while the block is idle (not enforced here)
	cct_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Classify on the way in, so the input register carries the class
	cct_classify #(.SET_SLOTS(SET_SLOTS)) u_cls (
		.cfg     (cfg),
		.kind    (kind),
		.in_byte (in_byte),
		.item    (item_in)
	);

	// Advance the held item once its results have room; an item that gives
	// no result never waits for the output side
	assign adv      = v_s1 && ((sout.n == 2'd0) || free);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Payload of the input register: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

	// Mode machine: results and next state from the held item
	cct_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.adv    (adv),
		.sout   (sout)
	);

	// Result register: drains one result per output transfer
	cct_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.sout       (sout),
		.push       (adv),
		.free       (free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_res  (event_res),
		.out_byte   (out_byte),
		.line_count (line_count),
		.last       (last)
	);

endmodule

// ----- rtl/cct_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cct_cfg_regs
// APB-style register file holding the character sets and escape byte.
// ----------------------------------------------------------------------------
module cct_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cct_pkg::CFG_AW-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	output cct_pkg::cfg_t              cfg
);

	localparam logic [2:0] REG_WORD   = 3'd0;
	localparam logic [2:0] REG_LINE   = 3'd1;
	localparam logic [2:0] REG_SYM    = 3'd2;
	localparam logic [2:0] REG_COPEN  = 3'd3;
	localparam logic [2:0] REG_CCLOSE = 3'd4;
	localparam logic [2:0] REG_ESC    = 3'd5;
	localparam logic [2:0] REG_EXTRA  = 3'd6;

	cct_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[cct_pkg::CFG_AW-1:3];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.word_set   <= 64'h0000_0000_0000_0920;
			cfg_q.line_set   <= 64'h0000_0000_0000_0D0A;
			cfg_q.sym_set    <= '0;
			cfg_q.copen_set  <= '0;
			cfg_q.cclose_set <= '0;
			cfg_q.esc_byte   <= '0;
			cfg_q.extra_set  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_WORD:   cfg_q.word_set   <= pwdata;
				REG_LINE:   cfg_q.line_set   <= pwdata;
				REG_SYM:    cfg_q.sym_set    <= pwdata;
				REG_COPEN:  cfg_q.copen_set  <= pwdata;
				REG_CCLOSE: cfg_q.cclose_set <= pwdata;
				REG_ESC:    cfg_q.esc_byte   <= pwdata[7:0];
				REG_EXTRA:  cfg_q.extra_set  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WORD:   prdata = cfg_q.word_set;
			REG_LINE:   prdata = cfg_q.line_set;
			REG_SYM:    prdata = cfg_q.sym_set;
			REG_COPEN:  prdata = cfg_q.copen_set;
			REG_CCLOSE: prdata = cfg_q.cclose_set;
			REG_ESC:    prdata = {56'h0, cfg_q.esc_byte};
			REG_EXTRA:  prdata = cfg_q.extra_set;
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- rtl/cct_classify.sv -----
// ----------------------------------------------------------------------------
// cct_classify
// Parallel set compares and class priority for one input byte.
// ----------------------------------------------------------------------------
module cct_classify #(
	parameter int SET_SLOTS = 8
) (
	input  cct_pkg::cfg_t cfg,
	input  logic          kind,
	input  logic [7:0]    in_byte,
	output cct_pkg::item_t item
);

	function automatic logic in_set(input logic [63:0] set, input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SET_SLOTS; i++) begin
			if (set[8*i +: 8] != 8'h00 && set[8*i +: 8] == c)
				hit = 1'b1;
		end
		return hit;
	endfunction

	cct_pkg::cls_t cls;

	always_comb begin
		if (kind)
			cls = cct_pkg::CLS_OTHER;
		else if (in_set(cfg.line_set, in_byte))
			cls = cct_pkg::CLS_LINE;
		else if (in_set(cfg.word_set, in_byte))
			cls = cct_pkg::CLS_WORD;
		else if (in_set(cfg.sym_set, in_byte))
			cls = cct_pkg::CLS_SYM;
		else if (in_set(cfg.copen_set, in_byte))
			cls = cct_pkg::CLS_COPEN;
		else if (in_set(cfg.cclose_set, in_byte))
			cls = cct_pkg::CLS_CCLOSE;
		else if (cfg.esc_byte != 8'h00 && in_byte == cfg.esc_byte)
			cls = cct_pkg::CLS_ESC;
		else
			cls = cct_pkg::CLS_OTHER;
	end

	assign item.eos    = kind;
	assign item.data   = in_byte;
	assign item.cls    = cls;
	assign item.xdelim = in_set(cfg.extra_set, in_byte);

endmodule

// ----- rtl/cct_step.sv -----
// ----------------------------------------------------------------------------
// cct_step
// Mode machine: forms the results of one classified item and holds the
// tokenizer state.
// ----------------------------------------------------------------------------
module cct_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cct_pkg::item_t       item,
	input  logic                 adv,
	output cct_pkg::step_out_t   sout
);

	typedef enum logic [2:0] {
		M_BETWEEN,
		M_TOKEN,
		M_ESCAPED,
		M_COMMENT,
		M_ENDED
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [7:0]  plb_q, plb_d;
	logic        plv_q, plv_d;
	logic [15:0] line_cnt_q, line_cnt_d;

	// Outcome of the byte taken as between tokens
	logic          bt_emit;
	cct_pkg::ev_t  bt_ev;
	logic [7:0]    bt_byte;
	mode_t         bt_mode;
	logic          bt_line;

	logic          do_line;
	logic [1:0]    n;
	cct_pkg::ev_t  ev0, ev1;
	logic [7:0]    b0, b1;
	logic          skip;
	logic          tok_cls;

	assign tok_cls = (item.cls == cct_pkg::CLS_OTHER) || (item.cls == cct_pkg::CLS_ESC);
	assign skip = plv_q && !item.eos && (item.cls == cct_pkg::CLS_LINE) &&
		(item.data != plb_q);

	always_comb begin
		bt_emit = 1'b0;
		bt_ev   = cct_pkg::EV_TOKEN_BYTE;
		bt_byte = 8'h00;
		bt_mode = M_BETWEEN;
		bt_line = 1'b0;
		case (item.cls)
			cct_pkg::CLS_OTHER, cct_pkg::CLS_ESC: begin
				if (!item.xdelim) begin
					bt_emit = 1'b1;
					bt_byte = item.data;
					bt_mode = (item.cls == cct_pkg::CLS_ESC) ? M_ESCAPED : M_TOKEN;
				end
			end
			cct_pkg::CLS_SYM: begin
				bt_emit = 1'b1;
				bt_ev   = cct_pkg::EV_SYMBOL;
				bt_byte = item.data;
			end
			cct_pkg::CLS_LINE: begin
				bt_emit = 1'b1;
				bt_ev   = cct_pkg::EV_LINE_END;
				bt_line = 1'b1;
			end
			cct_pkg::CLS_COPEN: bt_mode = M_COMMENT;
			cct_pkg::CLS_CCLOSE: begin
				bt_emit = 1'b1;
				bt_ev   = cct_pkg::EV_STRAY_CLOSE;
			end
			default: ;
		endcase
	end

	always_comb begin
		n       = 2'd0;
		ev0     = cct_pkg::EV_TOKEN_BYTE;
		ev1     = cct_pkg::EV_TOKEN_BYTE;
		b0      = 8'h00;
		b1      = 8'h00;
		mode_d  = mode_q;
		plv_d   = plv_q;
		plb_d   = plb_q;
		do_line = 1'b0;
		case (mode_q)
			M_BETWEEN: begin
				plv_d = 1'b0;
				if (skip) begin
					n = 2'd0;
				end else if (item.eos) begin
					n      = 2'd1;
					ev0    = cct_pkg::EV_STREAM_END;
					mode_d = M_ENDED;
				end else begin
					n       = {1'b0, bt_emit};
					ev0     = bt_ev;
					b0      = bt_byte;
					mode_d  = bt_mode;
					do_line = bt_line;
				end
			end
			M_TOKEN: begin
				if (item.eos) begin
					n      = 2'd2;
					ev0    = cct_pkg::EV_TOKEN_END;
					ev1    = cct_pkg::EV_STREAM_END;
					mode_d = M_ENDED;
				end else if (tok_cls) begin
					n = 2'd1;
					if (item.xdelim) begin
						ev0    = cct_pkg::EV_TOKEN_END;
						mode_d = M_BETWEEN;
					end else begin
						b0 = item.data;
						if (item.cls == cct_pkg::CLS_ESC)
							mode_d = M_ESCAPED;
					end
				end else if (item.cls == cct_pkg::CLS_WORD) begin
					n      = 2'd1;
					ev0    = cct_pkg::EV_TOKEN_END;
					mode_d = M_BETWEEN;
				end else if (item.cls == cct_pkg::CLS_CCLOSE) begin
					n      = 2'd1;
					ev0    = cct_pkg::EV_STRAY_CLOSE;
					mode_d = M_BETWEEN;
				end else begin
					// close the token, then treat the byte as between tokens
					n       = bt_emit ? 2'd2 : 2'd1;
					ev0     = cct_pkg::EV_TOKEN_END;
					ev1     = bt_ev;
					b1      = bt_byte;
					mode_d  = bt_mode;
					do_line = bt_line;
				end
			end
			M_ESCAPED: begin
				n = 2'd1;
				if (item.eos) begin
					ev0    = cct_pkg::EV_ESC_AT_END;
					mode_d = M_ENDED;
				end else begin
					b0     = item.data;
					mode_d = M_TOKEN;
				end
			end
			M_COMMENT: begin
				if (item.eos) begin
					n      = 2'd1;
					ev0    = cct_pkg::EV_STREAM_END;
					mode_d = M_ENDED;
				end else if (item.cls == cct_pkg::CLS_CCLOSE) begin
					mode_d = M_BETWEEN;
				end else if (item.cls == cct_pkg::CLS_LINE) begin
					n       = 2'd1;
					ev0     = cct_pkg::EV_LINE_END;
					mode_d  = M_BETWEEN;
					do_line = 1'b1;
				end
			end
			default: mode_d = M_ENDED;
		endcase
		if (do_line) begin
			plb_d = item.data;
			plv_d = 1'b1;
		end
	end

	assign line_cnt_d = line_cnt_q + {15'h0, do_line};

	// A line end is always the last result, so it alone sees the new count
	assign sout.n        = n;
	assign sout.r0.ev    = ev0;
	assign sout.r0.data  = b0;
	assign sout.r0.count = (ev0 == cct_pkg::EV_LINE_END) ? line_cnt_d : line_cnt_q;
	assign sout.r1.ev    = ev1;
	assign sout.r1.data  = b1;
	assign sout.r1.count = (ev1 == cct_pkg::EV_LINE_END) ? line_cnt_d : line_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_BETWEEN;
			plb_q      <= 8'h00;
			plv_q      <= 1'b0;
			line_cnt_q <= 16'h0000;
		end else if (adv) begin
			mode_q     <= mode_d;
			plb_q      <= plb_d;
			plv_q      <= plv_d;
			line_cnt_q <= line_cnt_d;
		end
	end

endmodule

// ----- rtl/cct_out_stage.sv -----
// ----------------------------------------------------------------------------
// cct_out_stage
// Two-slot result register; presents one result per transfer.
// ----------------------------------------------------------------------------
`include "char_class_tokenizer_macros.svh"

module cct_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  cct_pkg::step_out_t sout,
	input  logic               push,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_res,
	output logic [7:0]         out_byte,
	output logic [15:0]        line_count,
	output logic               last
);

	cct_pkg::res_t slot0_s2, slot1_s2;
	logic          v0_s2, v1_s2;
	logic          load;
	logic          xfer;

	assign xfer = v0_s2 && out_ready;
	assign free = !v0_s2 || (out_ready && !v1_s2);
	assign load = push && (sout.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s2 <= 1'b0;
			v1_s2 <= 1'b0;
		end else if (load) begin
			v0_s2 <= 1'b1;
			v1_s2 <= (sout.n == 2'd2);
		end else if (xfer) begin
			v0_s2 <= v1_s2;
			v1_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_s2 <= sout.r0;
			slot1_s2 <= sout.r1;
		end else if (xfer) begin
			slot0_s2 <= slot1_s2;
		end
	end

	assign out_valid  = v0_s2;
	assign event_res  = slot0_s2.ev;
	assign out_byte   = slot0_s2.data;
	assign line_count = slot0_s2.count;
	assign last       = !v1_s2;

	`CCT_ASSERT_IMPL(a_slot_order, v1_s2, v0_s2, "second result slot filled without the first")
	`CCT_ASSERT_IMPL(a_load_free, load, free, "results loaded over a pending result")
	`CCT_ASSERT_NEXT(a_second_moves, v0_s2 && v1_s2 && out_ready, v0_s2 && !v1_s2, "second result lost after transfer")

endmodule
